// ===== src/rtcseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcseq_pkg
// Shared types, status codes, control bit masks and BCD helpers for the
// RTC time sequencer on an I2C master controller.
// ----------------------------------------------------------------------------
package rtcseq_pkg;

    // number of time bytes written after the register pointer
    localparam int unsigned TIME_BYTES = 3;

    // control register bit masks
    localparam logic [6:0] CTRL_STA  = 7'h20;
    localparam logic [6:0] CTRL_STO  = 7'h10;
    localparam logic [6:0] CTRL_SI   = 7'h08;
    localparam logic [6:0] CTRL_AA   = 7'h04;
    localparam logic [6:0] CTRL_NONE = 7'h00;

    // device address after reset
    localparam logic [6:0] DEV_ADDR_RST = 7'd104;

    // controller status codes
    localparam logic [7:0] ST_BUS_ERROR = 8'h00;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    // byte counter values
    localparam logic [2:0] CNT_MAX     = 3'd7;
    localparam logic [2:0] CNT_MINUTES = 3'd1;
    localparam logic [2:0] CNT_HOURS   = 3'd2;
    localparam logic [2:0] CNT_LAST_RX = 3'(TIME_BYTES - 1);
    localparam logic [2:0] CNT_LAST_TX = 3'(TIME_BYTES);

    // item kinds
    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_READ   = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // one input item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
    } t_item;

    // sequencer state; the transmit bytes have no reset value
    typedef struct packed {
        logic       read_phase_pending;
        logic       read_busy;
        logic [2:0] byte_count;
        logic       register_pointer;
        logic [7:0] tx_minutes;
        logic [7:0] tx_hours;
        logic [7:0] rx_minutes;
        logic [7:0] rx_hours;
    } t_state;

    // one result item
    typedef struct packed {
        logic [6:0] ctrl_set_bits;
        logic [6:0] ctrl_clear_bits;
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       busy_res;
        logic [6:0] time_hour;
        logic [6:0] time_minute;
    } t_result;

    // binary 0..63 to packed BCD; tens by multiply with 13/128
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [5:0] ones;
        prod = {4'd0, v} * 10'd13;
        tens = prod[9:7];
        ones = v - ({3'd0, tens} * 6'd10);
        return {1'b0, tens, ones[3:0]};
    endfunction

    // packed BCD to binary, saturating at 99
    function automatic logic [6:0] from_bcd(input logic [7:0] b);
        logic [7:0] v;
        v = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
        return (v > 8'd99) ? 7'd99 : v[6:0];
    endfunction

endpackage

// ===== src/rtc_time_i2c_master_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_time_i2c_master_sequencer_core
// Sequences an I2C master controller to set or read an RTC's hour and minute.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   kind, status_code, rx_byte,
//                                                  set_hour, set_minute
//   out       output     o_out_valid / i_out_ready ctrl bits, tx byte, busy,
//                                                  time_hour, time_minute
//   cfg       input      i_cfg_we                  i_cfg_wdata (device address)
//
// One item per cycle sustained while results are taken; an item passes the
// input register, then the decision logic into the result register, and the
// state register updates together with the result register.
// A stalled result register stalls the input register, which still takes
// one item while the result waits.
// Synchronous active-low reset clears the state except the transmit bytes and sets address 104.
// ----------------------------------------------------------------------------
module rtc_time_i2c_master_sequencer_core
    import rtcseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_status_code,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_set_hour,
    input  logic [5:0] i_set_minute,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_ctrl_set_bits,
    output logic [6:0] o_ctrl_clear_bits,
    output logic       o_tx_load,
    output logic [7:0] o_tx_byte,
    output logic       o_busy_res,
    output logic [6:0] o_time_hour,
    output logic [6:0] o_time_minute
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    n_out;
    logic [6:0] r_dev_addr;
    logic       proc_fire;
    logic       in_fire;

    // handshake: the input register moves on when the result slot frees
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.kind        <= t_kind'(i_kind);
            r_in.status_code <= i_status_code;
            r_in.rx_byte     <= i_rx_byte;
            r_in.set_hour    <= i_set_hour;
            r_in.set_minute  <= i_set_minute;
        end
    end

    // decision logic
    rtcseq_step u_step (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_dev_addr   (r_dev_addr),
        .o_state_next (n_state),
        .o_result     (n_out)
    );

    // sequencer state; transmit bytes are loaded only by set requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.read_phase_pending <= 1'b0;
            r_state.read_busy          <= 1'b0;
            r_state.byte_count         <= 3'd0;
            r_state.register_pointer   <= 1'b0;
            r_state.rx_minutes         <= 8'h00;
            r_state.rx_hours           <= 8'h00;
        end else if (proc_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out <= n_out;
        end
    end

    // output ports
    assign o_out_valid       = r_out_valid;
    assign o_ctrl_set_bits   = r_out.ctrl_set_bits;
    assign o_ctrl_clear_bits = r_out.ctrl_clear_bits;
    assign o_tx_load         = r_out.tx_load;
    assign o_tx_byte         = r_out.tx_byte;
    assign o_busy_res        = r_out.busy_res;
    assign o_time_hour       = r_out.time_hour;
    assign o_time_minute     = r_out.time_minute;

    // a processed item always lands in the result register
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> o_out_valid)
        else $error("processed item did not reach the result register");

    // no transmit byte without a load
    a_tx_zero_unloaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_load) |-> (o_tx_byte == 8'h00))
        else $error("tx byte nonzero without load");

    // decoded time stays in decimal range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_time_hour <= 7'd99 && o_time_minute <= 7'd99))
        else $error("decoded time out of range");

    // a set request only asks for a start
    a_set_gives_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in.kind == KIND_SET) |=>
        (o_ctrl_set_bits == CTRL_STA && o_ctrl_clear_bits == CTRL_NONE && !o_tx_load))
        else $error("set request did not produce a plain start");

endmodule

// ===== src/rtcseq_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcseq_step
// Decision logic for one item: from the registered item and the current
// state, gives the controller bits, transmit byte, next state and decoded time.
// ----------------------------------------------------------------------------
module rtcseq_step
    import rtcseq_pkg::*;
(
    input  t_item      i_item,
    input  t_state     i_state,
    input  logic [6:0] i_dev_addr,
    output t_state     o_state_next,
    output t_result    o_result
);

    t_state     n_st;
    logic [6:0] set_v;
    logic [6:0] clr_v;
    logic       load;
    logic [7:0] txb;
    logic [2:0] cnt_up;

    // saturating byte counter increment
    assign cnt_up = (i_state.byte_count == CNT_MAX) ? CNT_MAX
                                                    : i_state.byte_count + 3'd1;

    // per-item control decision and state update
    always_comb begin
        n_st  = i_state;
        set_v = CTRL_NONE;
        clr_v = CTRL_NONE;
        load  = 1'b0;
        txb   = 8'h00;
        case (i_item.kind)
            KIND_SET: begin
                n_st.tx_minutes         = to_bcd(i_item.set_minute);
                n_st.tx_hours           = to_bcd({1'b0, i_item.set_hour});
                n_st.register_pointer   = 1'b0;
                n_st.byte_count         = 3'd0;
                n_st.read_phase_pending = 1'b0;
                set_v                   = CTRL_STA;
            end
            KIND_READ: begin
                n_st.register_pointer   = 1'b1;
                n_st.read_phase_pending = 1'b1;
                n_st.read_busy          = 1'b1;
                n_st.byte_count         = 3'd0;
                set_v                   = CTRL_STA;
            end
            KIND_STATUS: begin
                case (i_item.status_code)
                    ST_BUS_ERROR, ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK: begin
                        set_v                   = CTRL_STO | CTRL_AA;
                        clr_v                   = CTRL_SI;
                        n_st.read_busy          = 1'b0;
                        n_st.read_phase_pending = 1'b0;
                    end
                    ST_START: begin
                        load  = 1'b1;
                        txb   = {i_dev_addr, 1'b0};
                        set_v = CTRL_AA;
                        clr_v = CTRL_STA | CTRL_SI;
                    end
                    ST_RESTART: begin
                        load  = 1'b1;
                        txb   = {i_dev_addr, 1'b1};
                        set_v = CTRL_AA;
                        clr_v = CTRL_STA | CTRL_SI;
                    end
                    ST_SLAW_ACK: begin
                        load            = 1'b1;
                        txb             = {7'd0, i_state.register_pointer};
                        set_v           = CTRL_AA;
                        clr_v           = CTRL_SI;
                        n_st.byte_count = cnt_up;
                    end
                    ST_DATA_ACK: begin
                        if (i_state.read_phase_pending) begin
                            // pointer sent, turn around with repeated start
                            set_v                   = CTRL_STA;
                            clr_v                   = CTRL_SI;
                            n_st.read_phase_pending = 1'b0;
                        end else if (i_state.byte_count >= 3'd1 &&
                                     i_state.byte_count <= CNT_LAST_TX) begin
                            load            = 1'b1;
                            set_v           = CTRL_AA;
                            clr_v           = CTRL_SI;
                            n_st.byte_count = cnt_up;
                            // seconds byte first, always zero
                            case (i_state.byte_count)
                                CNT_MINUTES: txb = 8'h00;
                                CNT_HOURS:   txb = i_state.tx_minutes;
                                default:     txb = i_state.tx_hours;
                            endcase
                        end else begin
                            set_v = CTRL_STO | CTRL_AA;
                            clr_v = CTRL_SI;
                        end
                    end
                    ST_ARB_LOST: begin
                        set_v = CTRL_STA | CTRL_AA;
                        clr_v = CTRL_SI;
                    end
                    ST_SLAR_ACK: begin
                        set_v = CTRL_AA;
                        clr_v = CTRL_SI;
                    end
                    ST_RX_ACK: begin
                        if (i_state.byte_count == CNT_MINUTES) begin
                            n_st.rx_minutes = i_item.rx_byte;
                        end else if (i_state.byte_count == CNT_HOURS) begin
                            n_st.rx_hours = i_item.rx_byte;
                        end
                        n_st.byte_count = cnt_up;
                        // nack the last byte
                        if (cnt_up == CNT_LAST_RX) begin
                            clr_v = CTRL_SI | CTRL_AA;
                        end else begin
                            set_v = CTRL_AA;
                            clr_v = CTRL_SI;
                        end
                    end
                    ST_RX_NACK: begin
                        if (i_state.byte_count == CNT_MINUTES) begin
                            n_st.rx_minutes = i_item.rx_byte;
                        end else if (i_state.byte_count == CNT_HOURS) begin
                            n_st.rx_hours = i_item.rx_byte;
                        end
                        set_v          = CTRL_STO | CTRL_AA;
                        clr_v          = CTRL_SI;
                        n_st.read_busy = 1'b0;
                    end
                    default: begin
                        set_v = CTRL_NONE;
                    end
                endcase
            end
            default: begin
                set_v = CTRL_NONE;
            end
        endcase
    end

    // result assembly with time decoded from the updated receive bytes
    assign o_state_next             = n_st;
    assign o_result.ctrl_set_bits   = set_v;
    assign o_result.ctrl_clear_bits = clr_v;
    assign o_result.tx_load         = load;
    assign o_result.tx_byte         = txb;
    assign o_result.busy_res        = n_st.read_busy;
    assign o_result.time_hour       = from_bcd(n_st.rx_hours);
    assign o_result.time_minute     = from_bcd(n_st.rx_minutes);

endmodule
